// ===== rtl/lps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types and constants of the two-channel LED pulse sequencer.
// ----------------------------------------------------------------------------
package lps_pkg;

  localparam int unsigned LevelW   = 8;
  localparam int unsigned ModeW    = 4;
  localparam int unsigned CountW   = 12;
  localparam int unsigned CompareW = 10;
  localparam int unsigned KindW    = 2;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 32;

  // counter bits watched by slow and fast pulses
  localparam int unsigned SlowBit = 9;
  localparam int unsigned FastBit = 6;

  localparam logic [CompareW-1:0] CompareTop = CompareW'(512);

  localparam logic [ModeW-1:0] ModeSolid   = 4'd0;
  localparam logic [ModeW-1:0] ModeSlowOne = 4'd1;
  localparam logic [ModeW-1:0] ModeSlowMax = 4'd4;
  localparam logic [ModeW-1:0] ModeFastOne = 4'd5;
  localparam logic [ModeW-1:0] ModeFastMax = 4'd8;

  localparam logic [LevelW-1:0] IdleLevelAReset = 8'd64;
  localparam logic [LevelW-1:0] IdleLevelBReset = 8'd0;
  localparam logic [LevelW-1:0] FullLevelReset  = 8'd255;

  typedef enum logic [KindW-1:0] {
    KIND_TICK     = 2'd0,
    KIND_SET_MODE = 2'd1,
    KIND_SET_ON   = 2'd2
  } kind_e;

  typedef enum logic [CfgAddrW-1:0] {
    REG_IDLE_LEVEL_A = 2'd0,
    REG_IDLE_LEVEL_B = 2'd1,
    REG_FULL_LEVEL   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic              on;
    logic [LevelW-1:0] level;
  } chan_state_t;

  // one item as seen by a channel
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             addressed;
    logic [ModeW-1:0] mode;
    logic             on;
    logic             slow_was;
    logic             slow_now;
    logic             fast_was;
    logic             fast_now;
  } chan_cmd_t;

endpackage

// ===== rtl/lps_channel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_channel
// Next-state logic of one LED channel: commands and tick-driven pulses.
// ----------------------------------------------------------------------------
module lps_channel (
  input  lps_pkg::chan_state_t                  cur_i,
  input  lps_pkg::chan_cmd_t                    cmd_i,
  input  logic [lps_pkg::LevelW-1:0]            idle_level_i,
  input  logic [lps_pkg::LevelW-1:0]            full_level_i,
  output lps_pkg::chan_state_t                  nxt_o
);
  import lps_pkg::*;

  logic             is_slow;
  logic             is_fast;
  logic             was;
  logic             now;
  logic [ModeW-1:0] first;

  assign is_slow = (cur_i.mode >= ModeSlowOne) && (cur_i.mode <= ModeSlowMax);
  assign is_fast = (cur_i.mode >= ModeFastOne) && (cur_i.mode <= ModeFastMax);
  assign was     = is_slow ? cmd_i.slow_was : cmd_i.fast_was;
  assign now     = is_slow ? cmd_i.slow_now : cmd_i.fast_now;
  assign first   = is_slow ? ModeSlowOne : ModeFastOne;

  always_comb begin
    nxt_o = cur_i;
    unique case (cmd_i.kind)
      KIND_TICK: begin
        if (is_slow || is_fast) begin
          if (!was && now) begin
            nxt_o.level = full_level_i;
          end else if (was && !now && (cur_i.level != idle_level_i)) begin
            // pulse done: count it down, back to solid after the last one
            nxt_o.level = idle_level_i;
            nxt_o.mode  = (cur_i.mode > first) ? cur_i.mode - 1'b1 : ModeSolid;
          end
        end else begin
          nxt_o.level = cur_i.on ? full_level_i : idle_level_i;
        end
      end
      KIND_SET_MODE: begin
        if (cmd_i.addressed && (cmd_i.mode <= ModeFastMax)) begin
          nxt_o.mode = cmd_i.mode;
        end
      end
      KIND_SET_ON: begin
        if (cmd_i.addressed) begin
          nxt_o.on = cmd_i.on;
        end
      end
      default: begin
        nxt_o = cur_i;
      end
    endcase
  end

endmodule

// ===== rtl/led_pulse_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_pulse_sequencer
// Two-channel LED brightness sequencer driving anti-parallel LED PWM compares.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries items: tuser is the kind (tick, set mode, set on flag),
//   tdata the channel, mode and on flag. Every item yields one m_axis item
//   with compare_a (512 - level A), compare_b (level B) and both modes.
//   cfg_we_i/cfg_addr_i/cfg_wdata_i write the idle levels and the full
//   level; write only while no item is in flight.
// Timing:
//   An item is captured in the input register, is processed on its way
//   into the output register and appears on m_axis from there. One item
//   per cycle is sustained while m_axis_tready stays high; the channel
//   update is a single pass of compare/select logic between those two registers.
// Reset:
//   Counter, modes and on flags clear, levels load the reset idle levels,
//   registers take their reset values, both pipeline stages empty.
// Stall:
//   With m_axis_tready low the result holds; one more item can wait in
//   the input register, after which s_axis_tready drops.
// ----------------------------------------------------------------------------
module led_pulse_sequencer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // cfg
  input  logic                           cfg_we_i,
  input  logic [lps_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  logic [lps_pkg::LevelW-1:0]     cfg_wdata_i,
  // input items
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [lps_pkg::InDataW-1:0]    s_axis_tdata,  // channel, mode[3:0], on, 2'b0
  input  logic [lps_pkg::KindW-1:0]      s_axis_tuser,  // kind
  // result items
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [lps_pkg::OutDataW-1:0]   m_axis_tdata   // compare_a, compare_b,
                                                        // mode_a, mode_b, 6'b0
);
  import lps_pkg::*;

  logic [LevelW-1:0] idle_a_q, idle_b_q, full_q;

  logic               in_valid_q;
  logic [KindW-1:0]   in_kind_q;
  logic               in_chan_q;
  logic [ModeW-1:0]   in_mode_q;
  logic               in_on_q;

  logic               out_valid_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic [CountW-1:0]  tick_q, prev_q;
  chan_state_t        chan_a_q, chan_a_d, chan_b_q, chan_b_d;
  chan_cmd_t          cmd_a, cmd_b;

  logic advance;
  logic in_take;
  logic is_tick;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign is_tick       = (in_kind_q == KIND_TICK);

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_a_q <= IdleLevelAReset;
      idle_b_q <= IdleLevelBReset;
      full_q   <= FullLevelReset;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_IDLE_LEVEL_A: idle_a_q <= cfg_wdata_i;
        REG_IDLE_LEVEL_B: idle_b_q <= cfg_wdata_i;
        REG_FULL_LEVEL:   full_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_kind_q <= s_axis_tuser;
      in_chan_q <= s_axis_tdata[0];
      in_mode_q <= s_axis_tdata[4:1];
      in_on_q   <= s_axis_tdata[5];
    end
  end

  // channel update
  always_comb begin
    cmd_a.kind      = in_kind_q;
    cmd_a.addressed = !in_chan_q;
    cmd_a.mode      = in_mode_q;
    cmd_a.on        = in_on_q;
    cmd_a.slow_was  = prev_q[SlowBit];
    cmd_a.slow_now  = tick_q[SlowBit];
    cmd_a.fast_was  = prev_q[FastBit];
    cmd_a.fast_now  = tick_q[FastBit];
    cmd_b           = cmd_a;
    cmd_b.addressed = in_chan_q;
  end

  lps_channel u_chan_a (
    .cur_i        (chan_a_q),
    .cmd_i        (cmd_a),
    .idle_level_i (idle_a_q),
    .full_level_i (full_q),
    .nxt_o        (chan_a_d)
  );

  lps_channel u_chan_b (
    .cur_i        (chan_b_q),
    .cmd_i        (cmd_b),
    .idle_level_i (idle_b_q),
    .full_level_i (full_q),
    .nxt_o        (chan_b_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q   <= '0;
      prev_q   <= '0;
      chan_a_q <= '{mode: ModeSolid, on: 1'b0, level: IdleLevelAReset};
      chan_b_q <= '{mode: ModeSolid, on: 1'b0, level: IdleLevelBReset};
    end else if (advance) begin
      chan_a_q <= chan_a_d;
      chan_b_q <= chan_b_d;
      if (is_tick) begin
        prev_q <= tick_q;
        tick_q <= tick_q + 1'b1;
      end
    end
  end

  // result register
  always_comb begin
    out_data_d        = '0;
    out_data_d[9:0]   = CompareTop - {{(CompareW-LevelW){1'b0}}, chan_a_d.level};
    out_data_d[17:10] = chan_b_d.level;
    out_data_d[21:18] = chan_a_d.mode;
    out_data_d[25:22] = chan_b_d.mode;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== tb/led_pulse_sequencer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_pulse_sequencer_checker
// Follows register writes and accepted items of the LED pulse sequencer, keeps
// its own copy of counter, modes, on flags and levels, and compares each
// result item field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module led_pulse_sequencer_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lps_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  logic [lps_pkg::LevelW-1:0]     cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [lps_pkg::InDataW-1:0]    s_axis_tdata,  // channel, mode[3:0], on, 2'b0
  input  logic [lps_pkg::KindW-1:0]      s_axis_tuser,  // kind
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [lps_pkg::OutDataW-1:0]   m_axis_tdata,  // compare_a, compare_b,
                                                        // mode_a, mode_b, 6'b0
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o
);
  import lps_pkg::*;

  typedef struct packed {
    logic [ModeW-1:0]    mode_b;
    logic [ModeW-1:0]    mode_a;
    logic [LevelW-1:0]   compare_b;
    logic [CompareW-1:0] compare_a;
  } led_result_t;

  led_result_t       compares_q[$];
  led_result_t       seen;
  led_result_t       want;
  logic [LevelW-1:0] idle_lvl [2];
  logic [LevelW-1:0] full_lvl;
  logic [CountW-1:0] count_cur;
  logic [CountW-1:0] count_prev;
  logic [ModeW-1:0]  ch_mode [2];
  logic              ch_on [2];
  logic [LevelW-1:0] ch_level [2];
  int unsigned       mismatches = 0;

  assign fail_count_o = mismatches;

  // one channel on a tick, using the counter values from before the tick
  function automatic void advance_channel(int ch);
    int unsigned      bit_idx;
    logic [ModeW-1:0] first;
    logic             was_hi;
    logic             is_hi;
    if (ch_mode[ch] >= ModeSlowOne && ch_mode[ch] <= ModeSlowMax) begin
      bit_idx = SlowBit;
      first   = ModeSlowOne;
    end else if (ch_mode[ch] >= ModeFastOne && ch_mode[ch] <= ModeFastMax) begin
      bit_idx = FastBit;
      first   = ModeFastOne;
    end else begin
      ch_level[ch] = ch_on[ch] ? full_lvl : idle_lvl[ch];
      return;
    end
    was_hi = count_prev[bit_idx];
    is_hi  = count_cur[bit_idx];
    if (!was_hi && is_hi) begin
      ch_level[ch] = full_lvl;
    end else if (was_hi && !is_hi && ch_level[ch] != idle_lvl[ch]) begin
      // a pulse only counts if something other than idle was shown
      ch_level[ch] = idle_lvl[ch];
      ch_mode[ch]  = (ch_mode[ch] > first) ? ch_mode[ch] - 1'b1 : ModeSolid;
    end
  endfunction

  function automatic led_result_t apply_item(logic [KindW-1:0] kind,
                                             logic [InDataW-1:0] data);
    logic             ch;
    logic [ModeW-1:0] mode;
    led_result_t      res;
    ch   = data[0];
    mode = data[4:1];
    case (kind)
      KIND_TICK: begin
        advance_channel(0);
        advance_channel(1);
      end
      KIND_SET_MODE: begin
        if (mode <= ModeFastMax) ch_mode[ch] = mode;
      end
      KIND_SET_ON: ch_on[ch] = data[5];
      default: ;
    endcase
    res.compare_a = CompareTop - CompareW'(ch_level[0]);
    res.compare_b = ch_level[1];
    res.mode_a    = ch_mode[0];
    res.mode_b    = ch_mode[1];
    if (kind == KIND_TICK) begin
      count_prev = count_cur;
      count_cur  = count_cur + 1'b1;
    end
    return res;
  endfunction

  function automatic void flag(string what, int unsigned exp_val, int unsigned act_val);
    if (mismatches < 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_val, act_val);
    mismatches++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_lvl[0] = IdleLevelAReset;
      idle_lvl[1] = IdleLevelBReset;
      full_lvl    = FullLevelReset;
      count_cur   = '0;
      count_prev  = '0;
      ch_mode[0]  = ModeSolid;
      ch_mode[1]  = ModeSolid;
      ch_on[0]    = 1'b0;
      ch_on[1]    = 1'b0;
      ch_level[0] = IdleLevelAReset;
      ch_level[1] = IdleLevelBReset;
      compares_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_IDLE_LEVEL_A: idle_lvl[0] = cfg_wdata_i;
          REG_IDLE_LEVEL_B: idle_lvl[1] = cfg_wdata_i;
          REG_FULL_LEVEL:   full_lvl    = cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        compares_q.push_back(apply_item(s_axis_tuser, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        seen = m_axis_tdata[$bits(led_result_t)-1:0];
        if (compares_q.size() == 0) begin
          flag("unexpected item", 0, 32'(seen));
        end else begin
          want = compares_q.pop_front();
          if (seen.compare_a != want.compare_a)
            flag("compare_a", 32'(want.compare_a), 32'(seen.compare_a));
          if (seen.compare_b != want.compare_b)
            flag("compare_b", 32'(want.compare_b), 32'(seen.compare_b));
          if (seen.mode_a != want.mode_a)
            flag("mode_a", 32'(want.mode_a), 32'(seen.mode_a));
          if (seen.mode_b != want.mode_b)
            flag("mode_b", 32'(want.mode_b), 32'(seen.mode_b));
        end
      end
      pending_o <= compares_q.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives tick and command items into the LED pulse sequencer under several
// level settings and back-pressure patterns; the checker beside the block
// predicts and compares every result item.
// ----------------------------------------------------------------------------
module testbench;
  import lps_pkg::*;

  localparam logic [KindW-1:0] KindReserved = 2'd3;  // leaves all state alone
  localparam int unsigned PhaseItems = 290;
  localparam int unsigned HoldAfter  = 800;  // results before the long hold-off
  localparam int unsigned HoldCycles = 80;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i    = '0;
  logic [LevelW-1:0]   cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [KindW-1:0]    s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  int unsigned         fail_count;
  int unsigned         pending;
  int unsigned         tx_idle_pct   = 20;
  int unsigned         rx_idle_pct   = 51;
  int unsigned         results_seen  = 0;
  int unsigned         hold_left     = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  led_pulse_sequencer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  led_pulse_sequencer_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // result side: random back-pressure, plus one long hold-off that fills the block
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) results_seen <= results_seen + 1;
    if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready && results_seen == HoldAfter) begin
      hold_left     <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_item(logic [KindW-1:0] kind, logic ch, logic [ModeW-1:0] mode,
                           logic on);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {2'b00, on, mode, ch};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // ticks carry random junk in the unused fields
  task automatic send_tick();
    send_item(KIND_TICK, 1'($urandom_range(1)), ModeW'($urandom_range(15)),
              1'($urandom_range(1)));
  endtask

  task automatic send_command();
    int unsigned      pick;
    logic [ModeW-1:0] mode;
    pick = $urandom_range(99);
    mode = ($urandom_range(99) < 85) ? ModeW'($urandom_range(8))
                                     : ModeW'($urandom_range(9, 15));
    if (pick < 55)
      send_item(KIND_SET_MODE, 1'($urandom_range(1)), mode, 1'($urandom_range(1)));
    else if (pick < 90)
      send_item(KIND_SET_ON, 1'($urandom_range(1)), ModeW'($urandom_range(15)),
                1'($urandom_range(1)));
    else
      send_item(KindReserved, 1'($urandom_range(1)), ModeW'($urandom_range(15)),
                1'($urandom_range(1)));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic set_levels(logic [LevelW-1:0] idle_a, logic [LevelW-1:0] idle_b,
                            logic [LevelW-1:0] full);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= REG_IDLE_LEVEL_A;
    cfg_wdata_i <= idle_a;
    @(posedge clk_i);
    cfg_addr_i  <= REG_IDLE_LEVEL_B;
    cfg_wdata_i <= idle_b;
    @(posedge clk_i);
    cfg_addr_i  <= REG_FULL_LEVEL;
    cfg_wdata_i <= full;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // a few commands, then a long run of ticks so that pulses can play out
  task automatic run_phase(int unsigned n_items);
    int unsigned sent;
    int unsigned run_len;
    sent = 0;
    while (sent < n_items) begin
      repeat ($urandom_range(1, 3)) begin
        send_command();
        sent++;
      end
      if (sent >= n_items) break;
      run_len = $urandom_range(10, 200);
      if (run_len > n_items - sent) run_len = n_items - sent;
      repeat (run_len) begin
        if ($urandom_range(99) < 2) send_command();
        else send_tick();
        sent++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, ignored mode codes, reserved kind, all modes
    send_item(KIND_TICK, 1'b1, 4'd15, 1'b1);
    send_item(KindReserved, 1'b1, 4'd15, 1'b1);
    send_item(KIND_SET_MODE, 1'b0, 4'd9, 1'b0);
    send_item(KIND_SET_MODE, 1'b1, 4'd15, 1'b1);
    send_item(KIND_SET_ON, 1'b0, 4'd0, 1'b1);
    send_item(KIND_SET_ON, 1'b1, 4'd0, 1'b1);
    send_item(KIND_TICK, 1'b0, 4'd0, 1'b0);
    send_item(KIND_SET_ON, 1'b0, 4'd0, 1'b0);
    send_item(KIND_TICK, 1'b0, 4'd0, 1'b0);
    send_item(KIND_SET_MODE, 1'b0, ModeSlowOne, 1'b0);
    send_item(KIND_SET_MODE, 1'b0, ModeSlowMax, 1'b0);
    send_item(KIND_SET_MODE, 1'b0, ModeFastOne, 1'b0);
    send_item(KIND_SET_MODE, 1'b0, ModeFastMax, 1'b0);
    send_item(KIND_SET_MODE, 1'b1, 4'd2, 1'b0);
    send_item(KIND_SET_MODE, 1'b1, 4'd6, 1'b0);
    send_item(KIND_SET_MODE, 1'b1, ModeSolid, 1'b0);
    send_item(KIND_SET_MODE, 1'b0, ModeSolid, 1'b0);
    send_item(KIND_SET_MODE, 1'b0, 4'd3, 1'b0);
    send_item(KIND_SET_MODE, 1'b1, 4'd7, 1'b0);
    send_item(KIND_TICK, 1'b0, 4'd0, 1'b0);
    send_item(KIND_SET_ON, 1'b1, 4'd0, 1'b0);
    send_item(KIND_TICK, 1'b1, 4'd0, 1'b0);
    send_item(KindReserved, 1'b0, 4'd0, 1'b0);
    send_item(KIND_TICK, 1'b0, 4'd0, 1'b0);

    // idle equal to full on B: its pulses never count down
    set_levels(8'd0, 8'd255, 8'd255);
    run_phase(PhaseItems);
    set_levels(8'd0, 8'd0, 8'd0);
    run_phase(PhaseItems);

    tx_idle_pct = 51;
    rx_idle_pct = 20;
    set_levels(LevelW'($urandom_range(255)), LevelW'($urandom_range(255)),
               LevelW'($urandom_range(255)));
    run_phase(PhaseItems);
    set_levels(8'd255, 8'd1, 8'd0);
    run_phase(PhaseItems);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    begin : last_phase
      logic [LevelW-1:0] lvl;
      lvl = LevelW'($urandom_range(255));
      set_levels(lvl, LevelW'($urandom_range(255)), lvl);
    end
    run_phase(PhaseItems);

    drain();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS led_pulse_sequencer");
    end else begin
      $display("FAIL led_pulse_sequencer");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL led_pulse_sequencer");
    $finish;
  end

endmodule
